/* src/int8_gemm_offset_compensated_macros.svh */
// assertion helpers for the gemm block
// both expect clk_i and rst_ni in the enclosing module
`ifndef INT8_GEMM_OFFSET_COMPENSATED_MACROS_SVH
`define INT8_GEMM_OFFSET_COMPENSATED_MACROS_SVH

// consequent checked in the same cycle
`define IGOC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define IGOC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/igoc_pkg.sv */
package igoc_pkg;

  // parameter defaults
  localparam int MaxColsDef  = 64;
  localparam int MaxDepthDef = 1024;

  // datapath shape
  localparam int LANES         = 8;
  localparam int LANE_W        = $clog2(LANES);
  localparam int OUT_COL_LIMIT = 64;

  // queue depths, powers of two
  localparam int CMD_Q_DEPTH = 2;
  localparam int OUT_Q_DEPTH = 4;
  localparam int OUT_CNT_W   = $clog2(OUT_Q_DEPTH + 1);

  // configuration port
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K_LEN  = 1'b0,
    CFG_N_COLS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [10:0] k_len;
    logic [6:0]  n_cols;
  } cfg_t;

  // input item modes
  typedef enum logic [1:0] {
    MODE_WEIGHT = 2'd0,
    MODE_OFFSET = 2'd1,
    MODE_ACT    = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic [5:0]          col_index;
    logic [9:0]          k_index;
    logic signed [7:0]   byte_value;
    logic signed [31:0]  offset_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         out_column;
    logic signed [31:0] dot_value;
    logic               row_last;
  } out_item_t;

  // commands between front and back
  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_OFFSET = 2'd1,
    CMD_ACT    = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [5:0]  col;
    logic [9:0]  k;
    logic [31:0] data;
  } cmd_t;

endpackage

/* src/igoc_fifo.sv */
module igoc_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  T                             data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output T                             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  // handshake status
  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* src/igoc_front.sv */
module igoc_front import igoc_pkg::*; #(
  parameter int MAX_COLS  = MaxColsDef,
  parameter int MAX_DEPTH = MaxDepthDef
) (
  input  logic     push,
  input  in_item_t in_item_i,
  output logic     full,
  input  logic     cmd_full_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  logic accept;
  logic keep;
  logic col_ok;
  logic k_ok;

  // input transfer whenever the command queue has room
  assign full   = cmd_full_i;
  assign accept = push && !cmd_full_i;

  // address range checks
  assign col_ok = (32'(in_item_i.col_index) < 32'(MAX_COLS));
  assign k_ok   = (32'(in_item_i.k_index) < 32'(MAX_DEPTH));

  // classify and build the command
  always_comb begin
    keep       = 1'b0;
    cmd_o.kind = CMD_ACT;
    cmd_o.col  = in_item_i.col_index;
    cmd_o.k    = in_item_i.k_index;
    cmd_o.data = '0;
    case (in_item_i.mode)
      MODE_WEIGHT: begin
        keep       = col_ok && k_ok;
        cmd_o.kind = CMD_WEIGHT;
        cmd_o.data = {24'd0, in_item_i.byte_value};
      end
      MODE_OFFSET: begin
        keep       = col_ok;
        cmd_o.kind = CMD_OFFSET;
        cmd_o.data = in_item_i.offset_value;
      end
      MODE_ACT: begin
        keep       = 1'b1;
        cmd_o.kind = CMD_ACT;
        // a + 128 as an unsigned byte
        cmd_o.data = {24'd0, ~in_item_i.byte_value[7], in_item_i.byte_value[6:0]};
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_push_o = accept && keep;

endmodule

/* src/igoc_back.sv */
`include "int8_gemm_offset_compensated_macros.svh"

module igoc_back import igoc_pkg::*; #(
  parameter int MAX_COLS  = MaxColsDef,
  parameter int MAX_DEPTH = MaxDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 cmd_empty_i,
  input  cmd_t                 cmd_i,
  output logic                 cmd_pop_o,
  input  logic [OUT_CNT_W-1:0] res_count_i,
  output logic                 res_push_o,
  output out_item_t            res_o
);

  localparam int NCOL       = (MAX_COLS < OUT_COL_LIMIT) ? MAX_COLS : OUT_COL_LIMIT;
  localparam int NGROUPS    = (NCOL + LANES - 1) / LANES;
  localparam int GW         = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int KW         = $clog2(MAX_DEPTH);
  localparam int KLW        = $clog2(MAX_DEPTH + 1);
  localparam int CIW        = $clog2(NCOL);
  localparam int CNW        = $clog2(NCOL + 1);
  localparam int BANK_DEPTH = MAX_DEPTH * (1 << GW);
  localparam int ACC_W      = LANES * 32;
  localparam int PW         = OUT_CNT_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [GW-1:0]       grp_q, grp_d;
  logic [KW-1:0]       k_q, k_d;
  logic [KW-1:0]       kpos_q, kpos_d;
  logic [7:0]          act_q, act_d;
  logic                row_end_q, row_end_d;
  logic [CIW-1:0]      col_q, col_d;
  logic [NGROUPS-1:0]  acc_vld_q, acc_vld_d;

  // effective configuration
  logic [KLW-1:0]      klen_eff;
  logic [CNW-1:0]      ncol_eff;
  logic [KLW-1:0]      k_ext;
  logic                k_last;
  logic [KW-1:0]       k_used;
  logic                col_last;
  logic [PW-1:0]       pend;
  logic                credit_ok;

  // memory controls
  logic                w_we;
  logic [LANE_W-1:0]   w_lane;
  logic [KW+GW-1:0]    w_waddr;
  logic [KW+GW-1:0]    w_raddr;
  logic                w_rd_en;
  logic [7:0]          w_rd [LANES];
  logic                off_we;
  logic                acc_rd_en;
  logic [GW-1:0]       acc_rd_row;
  logic                acc_fwd;
  logic                em_issue;
  logic                vld_clear;

  // mac stage
  logic                mac_vld_q;
  logic [GW-1:0]       mac_row_q;
  logic [ACC_W-1:0]    acc_rd_q;
  logic                acc_rd_vld_q;
  logic [ACC_W-1:0]    acc_old;
  logic signed [16:0]  prod [LANES];
  logic [ACC_W-1:0]    mac_sum;

  // emit stage
  logic                em_vld_q;
  logic [LANE_W-1:0]   em_lane_q;
  logic [5:0]          em_col_q;
  logic                em_last_q;
  logic [31:0]         off_rd_q;
  logic [31:0]         acc_sel;

  logic [31:0]         off_mem [NCOL];
  logic [ACC_W-1:0]    acc_mem [NGROUPS];

  // clamp row length and column count
  always_comb begin
    if (cfg_i.k_len == '0) begin
      klen_eff = KLW'(1);
    end else if (32'(cfg_i.k_len) > 32'(MAX_DEPTH)) begin
      klen_eff = KLW'(MAX_DEPTH);
    end else begin
      klen_eff = KLW'(cfg_i.k_len);
    end
    if (cfg_i.n_cols == '0) begin
      ncol_eff = CNW'(1);
    end else if (32'(cfg_i.n_cols) > 32'(NCOL)) begin
      ncol_eff = CNW'(NCOL);
    end else begin
      ncol_eff = CNW'(cfg_i.n_cols);
    end
  end

  // k position of the next element and row end
  assign k_ext    = KLW'(k_q);
  assign k_last   = (k_ext >= klen_eff - KLW'(1));
  assign k_used   = k_last ? KW'(klen_eff - KLW'(1)) : k_q;
  assign col_last = (CNW'(col_q) == ncol_eff - CNW'(1));

  // room in the result queue for one more transfer
  assign pend      = {1'b0, res_count_i} + PW'(em_vld_q);
  assign credit_ok = (pend < PW'(OUT_Q_DEPTH));

  // weight addressing
  assign w_lane  = cmd_i.col[LANE_W-1:0];
  assign w_waddr = {KW'(cmd_i.k), GW'(cmd_i.col >> LANE_W)};
  assign w_raddr = {kpos_q, grp_q};

  // sequencer
  always_comb begin
    state_d    = state_q;
    grp_d      = grp_q;
    k_d        = k_q;
    kpos_d     = kpos_q;
    act_d      = act_q;
    row_end_d  = row_end_q;
    col_d      = col_q;
    cmd_pop_o  = 1'b0;
    w_we       = 1'b0;
    off_we     = 1'b0;
    w_rd_en    = 1'b0;
    acc_rd_en  = 1'b0;
    acc_rd_row = grp_q;
    em_issue   = 1'b0;
    vld_clear  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_WEIGHT: begin
              w_we = 1'b1;
            end
            CMD_OFFSET: begin
              off_we = 1'b1;
            end
            CMD_ACT: begin
              act_d     = cmd_i.data[7:0];
              kpos_d    = k_used;
              row_end_d = k_last;
              k_d       = k_last ? '0 : k_q + 1'b1;
              grp_d     = '0;
              state_d   = ST_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SWEEP: begin
        // one group of eight columns per cycle
        w_rd_en   = 1'b1;
        acc_rd_en = 1'b1;
        grp_d     = grp_q + 1'b1;
        if (grp_q == GW'(NGROUPS - 1)) begin
          grp_d = '0;
          if (row_end_q) begin
            col_d   = '0;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        // one column per cycle while the result queue has room
        acc_rd_row = GW'(col_q >> LANE_W);
        if (credit_ok) begin
          em_issue  = 1'b1;
          acc_rd_en = 1'b1;
          col_d     = col_q + 1'b1;
          if (col_last) begin
            col_d     = '0;
            vld_clear = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // row valid bits, clear after the row wins over a late write
  always_comb begin
    acc_vld_d = acc_vld_q;
    if (mac_vld_q) begin
      acc_vld_d[mac_row_q] = 1'b1;
    end
    if (vld_clear) begin
      acc_vld_d = '0;
    end
  end

  assign acc_fwd = mac_vld_q && (mac_row_q == acc_rd_row);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      grp_q        <= '0;
      k_q          <= '0;
      row_end_q    <= 1'b0;
      col_q        <= '0;
      acc_vld_q    <= '0;
      mac_vld_q    <= 1'b0;
      acc_rd_vld_q <= 1'b0;
      em_vld_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      grp_q     <= grp_d;
      k_q       <= k_d;
      row_end_q <= row_end_d;
      col_q     <= col_d;
      acc_vld_q <= acc_vld_d;
      mac_vld_q <= (state_q == ST_SWEEP);
      em_vld_q  <= em_issue;
      if (acc_rd_en) begin
        acc_rd_vld_q <= acc_fwd || acc_vld_q[acc_rd_row];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kpos_q    <= kpos_d;
    act_q     <= act_d;
    mac_row_q <= grp_q;
    if (em_issue) begin
      em_lane_q <= col_q[LANE_W-1:0];
      em_col_q  <= 6'(col_q);
      em_last_q <= col_last;
    end
  end

  // weight banks, one per lane
  for (genvar l = 0; l < LANES; l++) begin : gen_bank
    logic [7:0] bank [BANK_DEPTH];
    logic [7:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (w_we && (w_lane == LANE_W'(l))) begin
        bank[w_waddr] <= cmd_i.data[7:0];
      end
      if (w_rd_en) begin
        rd_q <= bank[w_raddr];
      end
    end

    assign w_rd[l] = rd_q;
  end

  // column offset store
  always_ff @(posedge clk_i) begin
    if (off_we) begin
      off_mem[CIW'(cmd_i.col)] <= cmd_i.data;
    end
    if (em_issue) begin
      off_rd_q <= off_mem[col_q];
    end
  end

  // accumulator store, write data forwarded to a read of the same row
  always_ff @(posedge clk_i) begin
    if (mac_vld_q) begin
      acc_mem[mac_row_q] <= mac_sum;
    end
    if (acc_rd_en) begin
      if (acc_fwd) begin
        acc_rd_q <= mac_sum;
      end else begin
        acc_rd_q <= acc_mem[acc_rd_row];
      end
    end
  end

  // eight multiply-accumulate lanes
  always_comb begin
    acc_old = acc_rd_vld_q ? acc_rd_q : '0;
    for (int l = 0; l < LANES; l++) begin
      prod[l]              = $signed({1'b0, act_q}) * $signed(w_rd[l]);
      mac_sum[l*32 +: 32] = acc_old[l*32 +: 32] + 32'(prod[l]);
    end
  end

  // result transfer into the output queue
  assign acc_sel          = acc_old[em_lane_q*32 +: 32];
  assign res_push_o       = em_vld_q;
  assign res_o.out_column = em_col_q;
  assign res_o.dot_value  = signed'(acc_sel - off_rd_q);
  assign res_o.row_last   = em_last_q;

  `IGOC_ASSERT_NEXT(a_mac_follows_sweep, state_q == ST_SWEEP, mac_vld_q, "mac write missing after sweep read")
  `IGOC_ASSERT_NOW(a_res_room, res_push_o, res_count_i < OUT_CNT_W'(OUT_Q_DEPTH), "result queue overrun")
  `IGOC_ASSERT_NEXT(a_row_cleared, em_issue && col_last, acc_vld_q == '0 && state_q == ST_IDLE, "accumulators not cleared after row")

endmodule

/* src/int8_gemm_offset_compensated.sv */
// channel   direction  handshake              payload
// input     in         push / full            in_item_i  (mode, col, k, byte, offset)
// result    out        empty / pop            out_item_o (column, dot value, row last)
// config    in         cfg_we_i, no wait      cfg_idx_i, cfg_data_i
//
// weight and offset writes are stored as they are dequeued, an activation is
//   dequeued and then swept over the columns in groups of eight
// at row end the clamped n_cols results issue one per cycle while the result
//   queue has room, each via the emit registers and the result queue to the outputs
// reset is asynchronous; accumulators read as zero through per-row valid bits
// a 2-entry command queue and a 4-entry result queue let each side stall alone
module int8_gemm_offset_compensated import igoc_pkg::*; #(
  parameter int MAX_COLS  = MaxColsDef,
  parameter int MAX_DEPTH = MaxDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  in_item_t              in_item_i,
  output logic                  full,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t                 cfg_q, cfg_d;
  logic                 cmd_full;
  logic                 cmd_push;
  cmd_t                 cmd_in;
  logic                 cmd_empty;
  logic                 cmd_pop;
  cmd_t                 cmd_out;
  logic [OUT_CNT_W-1:0] res_count;
  logic                 res_push;
  out_item_t            res_item;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_K_LEN:  cfg_d.k_len  = cfg_data_i;
        CFG_N_COLS: cfg_d.n_cols = cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.k_len  <= 11'd1;
      cfg_q.n_cols <= 7'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classify input transfers
  igoc_front #(
    .MAX_COLS  (MAX_COLS),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_front (
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // command queue between front and back
  igoc_fifo #(
    .T     (cmd_t),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty),
    .count_o ()
  );

  // stores, mac lanes and result sequencing
  igoc_back #(
    .MAX_COLS  (MAX_COLS),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (res_item)
  );

  // result queue
  igoc_fifo #(
    .T     (out_item_t),
    .DEPTH (OUT_Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_item),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty),
    .count_o (res_count)
  );

endmodule

/* verif/tb_int8_gemm_offset_compensated.sv */
`timescale 1ns / 1ps

module tb_int8_gemm_offset_compensated;
  import igoc_pkg::*;

  localparam int ZERO_SHIFT    = 128;
  localparam int ROW_DEPTH     = 1024;
  localparam int COL_BOUND     = 64;
  localparam int FILLED_DEPTH  = 2;     // k positions loaded for every column
  localparam int RANDOM_ITEMS  = 104;
  localparam int SETTLE_CYCLES = 48;
  localparam int STALL_LIMIT   = 2000;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_e;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_REG,
    STEP_DRAIN
  } step_kind_e;

  typedef struct {
    step_kind_e            kind;
    in_item_t              item;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    idle_e                 idle;
  } step_t;

  // dut signals
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  in_item_t              in_item_i = '0;
  logic                  full;
  logic                  empty;
  logic                  pop = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_K_LEN;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // stimulus plan and expected results
  step_t     plan[$];
  out_item_t pending_dots[$];
  idle_e     idle_mode = IDLE_NONE;
  int        settle_cnt = 0;
  int        stall_cnt = 0;
  int        mismatches = 0;

  // gemm state mirror
  logic signed [7:0] wt_mem [COL_BOUND][ROW_DEPTH];
  int                col_off [COL_BOUND];
  int                col_acc [COL_BOUND] = '{default: 0};
  int unsigned       k_at = 0;
  logic [10:0]       k_len_q = 11'd1;
  logic [6:0]        n_cols_q = 7'd1;

  int8_gemm_offset_compensated dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // register write into the mirror
  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_K_LEN:  k_len_q = data[10:0];
      CFG_N_COLS: n_cols_q = data[6:0];
      default: ;
    endcase
  endtask

  // one accepted item through the mirror; row end queues the column dots
  task automatic apply_gemm_item(input in_item_t it);
    int unsigned klen;
    int unsigned ncol;
    int          act;
    out_item_t   dot;
    case (it.mode)
      MODE_WEIGHT: wt_mem[it.col_index][it.k_index] = it.byte_value;
      MODE_OFFSET: col_off[it.col_index] = it.offset_value;
      MODE_ACT: begin
        klen = (k_len_q == 0) ? 1 : ((k_len_q > ROW_DEPTH) ? ROW_DEPTH : k_len_q);
        if (k_at >= klen) k_at = klen - 1;
        act = $signed(it.byte_value) + ZERO_SHIFT;
        for (int c = 0; c < COL_BOUND; c++) begin
          col_acc[c] += act * int'(wt_mem[c][k_at]);
        end
        k_at++;
        if (k_at >= klen) begin
          ncol = (n_cols_q == 0) ? 1 : ((n_cols_q > COL_BOUND) ? COL_BOUND : n_cols_q);
          for (int c = 0; c < ncol; c++) begin
            dot.out_column = c[5:0];
            dot.dot_value  = col_acc[c] - col_off[c];
            dot.row_last   = (c == ncol - 1);
            pending_dots.push_back(dot);
          end
          col_acc = '{default: 0};
          k_at = 0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // plan building
  task automatic add_item(input logic [1:0] mode, input int col, input int k,
                          input logic [7:0] bval, input logic [31:0] off,
                          input idle_e idle);
    step_t s;
    s.kind = STEP_ITEM;
    s.item.mode = mode;
    s.item.col_index = col[5:0];
    s.item.k_index = k[9:0];
    s.item.byte_value = bval;
    s.item.offset_value = off;
    s.idx = CFG_K_LEN;
    s.data = '0;
    s.idle = idle;
    plan.push_back(s);
  endtask

  task automatic add_act(input logic [7:0] bval, input idle_e idle);
    add_item(MODE_ACT, $urandom_range(63), $urandom_range(1023), bval, $urandom, idle);
  endtask

  task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    step_t s;
    s.kind = STEP_REG;
    s.item = '0;
    s.idx = idx;
    s.data = data;
    s.idle = IDLE_NONE;
    plan.push_back(s);
  endtask

  // pause the sender until every queued dot has come out, then settle
  task automatic add_drain();
    step_t s;
    s.kind = STEP_DRAIN;
    s.item = '0;
    s.idx = CFG_K_LEN;
    s.data = '0;
    s.idle = IDLE_NONE;
    plan.push_back(s);
  endtask

  function automatic logic sender_rests(input idle_e idle);
    case (idle)
      IDLE_SENDER: return $urandom_range(99) < 46;
      IDLE_BOTH:   return $urandom_range(99) < 26;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_rests(input idle_e idle);
    case (idle)
      IDLE_RECEIVER: return $urandom_range(99) < 46;
      IDLE_BOTH:     return $urandom_range(99) < 26;
      default:       return 1'b0;
    endcase
  endfunction

  // stimulus plan, reset, and end of run
  initial begin
    int counted;
    int phase;
    int kl;
    int eff;
    int rows;
    int len;
    int sel;
    int nc;
    logic [7:0] bval;

    // offsets for every column, extremes included
    for (int c = 0; c < COL_BOUND; c++) begin
      add_item(MODE_OFFSET, c, $urandom_range(1023), 8'($urandom),
               (c == 5) ? 32'h8000_0000 : (c == 6) ? 32'h7fff_ffff : $urandom, IDLE_NONE);
    end
    // weights for the first k positions of every column
    for (int k = 0; k < FILLED_DEPTH; k++) begin
      for (int c = 0; c < COL_BOUND; c++) begin
        bval = 8'($urandom);
        if (k == 0 && c == 0) bval = 8'h80;
        if (k == 0 && c == 1) bval = 8'h7f;
        add_item(MODE_WEIGHT, c, k, bval, $urandom, IDLE_NONE);
      end
    end
    // far corner of the weight store
    add_item(MODE_WEIGHT, 63, 1023, 8'($urandom), $urandom, IDLE_NONE);

    // one-element rows at reset settings: zero shift, top shift, mid, unused mode
    add_act(8'h80, IDLE_NONE);
    add_act(8'h7f, IDLE_NONE);
    add_act(8'h00, IDLE_NONE);
    add_item(MODE_UNUSED, 0, 0, 8'hff, 32'hffff_ffff, IDLE_NONE);
    add_act(8'hff, IDLE_NONE);

    // full width, two deep
    add_drain();
    add_reg(CFG_N_COLS, 11'd64);
    add_reg(CFG_K_LEN, 11'd2);
    add_act(8'h7f, IDLE_NONE);
    add_act(8'h80, IDLE_NONE);
    add_act(8'h05, IDLE_NONE);
    add_act(8'hff, IDLE_NONE);

    // out-of-range column count and zero row length
    add_drain();
    add_reg(CFG_N_COLS, 11'd127);
    add_reg(CFG_K_LEN, 11'd0);
    add_act(8'($urandom), IDLE_NONE);

    // longest row, then a too-long length, then a length change mid-row
    add_drain();
    add_reg(CFG_N_COLS, 11'h780);
    add_reg(CFG_K_LEN, 11'd1024);
    add_act(8'($urandom), IDLE_NONE);
    add_drain();
    add_reg(CFG_K_LEN, 11'd2047);
    add_act(8'($urandom), IDLE_NONE);
    add_drain();
    add_reg(CFG_K_LEN, 11'd1);
    add_act(8'($urandom), IDLE_NONE);

    // random phases: well-formed rows with writes and noise mixed in
    counted = 0;
    phase = 0;
    while (counted < RANDOM_ITEMS) begin
      add_drain();
      kl = $urandom_range(FILLED_DEPTH);
      sel = $urandom_range(9);
      nc = (sel == 0) ? 64 : (sel == 1) ? ($urandom_range(1) ? 0 : 127) : $urandom_range(1, 64);
      add_reg(CFG_K_LEN, 11'(kl));
      add_reg(CFG_N_COLS, {4'($urandom), 7'(nc)});
      eff = (kl == 0) ? 1 : kl;
      rows = $urandom_range(2, 6);
      for (int r = 0; r < rows; r++) begin
        len = eff;
        // now and then leave the last row unfinished
        if (r == rows - 1 && $urandom_range(5) == 0) len = $urandom_range(eff - 1);
        for (int i = 0; i < len; i++) begin
          sel = $urandom_range(19);
          if (sel < 3) begin
            add_item(MODE_WEIGHT, $urandom_range(63), $urandom_range(1023), 8'($urandom),
                     $urandom, idle_e'(phase % 4));
            counted++;
          end else if (sel == 3) begin
            add_item(MODE_OFFSET, $urandom_range(63), $urandom_range(1023), 8'($urandom),
                     $urandom, idle_e'(phase % 4));
            counted++;
          end else if (sel == 4) begin
            add_item(MODE_UNUSED, $urandom_range(63), $urandom_range(1023), 8'($urandom),
                     $urandom, idle_e'(phase % 4));
          end
          add_act(8'($urandom), idle_e'(phase % 4));
          counted++;
        end
      end
      phase++;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (plan.size() != 0 || push || pending_dots.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // driver: presents plan steps, mirrors each accepted transfer
  always @(posedge clk_i or negedge rst_ni) begin : driver
    step_t                 hd;
    logic                  nxt_push;
    logic                  nxt_we;
    in_item_t              nxt_item;
    logic [CFG_IDX_W-1:0]  nxt_idx;
    logic [CFG_DATA_W-1:0] nxt_data;
    idle_e                 nxt_idle;
    if (!rst_ni) begin
      push <= 1'b0;
      cfg_we_i <= 1'b0;
    end else begin
      nxt_push = 1'b0;
      nxt_we = 1'b0;
      nxt_item = in_item_i;
      nxt_idx = cfg_idx_i;
      nxt_data = cfg_data_i;
      nxt_idle = idle_mode;
      if (push && !full) begin
        apply_gemm_item(in_item_i);
        void'(plan.pop_front());
      end
      if (cfg_we_i) begin
        apply_reg_write(cfg_idx_i, cfg_data_i);
        void'(plan.pop_front());
      end
      if (push && full) begin
        nxt_push = 1'b1;
      end else if (plan.size() != 0) begin
        hd = plan[0];
        case (hd.kind)
          STEP_ITEM: begin
            nxt_idle = hd.idle;
            if (!sender_rests(hd.idle)) begin
              nxt_push = 1'b1;
              nxt_item = hd.item;
            end
          end
          STEP_REG: begin
            nxt_we = 1'b1;
            nxt_idx = hd.idx;
            nxt_data = hd.data;
          end
          default: begin
            if (pending_dots.size() == 0) begin
              if (settle_cnt >= SETTLE_CYCLES) begin
                settle_cnt = 0;
                void'(plan.pop_front());
              end else begin
                settle_cnt++;
              end
            end
          end
        endcase
      end
      push <= nxt_push;
      in_item_i <= nxt_item;
      cfg_we_i <= nxt_we;
      cfg_idx_i <= nxt_idx;
      cfg_data_i <= nxt_data;
      idle_mode <= nxt_idle;
    end
  end

  // monitor: checks each result transfer against the oldest queued dot
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_dots.size() == 0) begin
          flag_mismatch("unexpected result column", out_item_o.out_column, -1);
        end else begin
          want = pending_dots.pop_front();
          if (out_item_o.out_column !== want.out_column)
            flag_mismatch("out_column", out_item_o.out_column, want.out_column);
          if (out_item_o.dot_value !== want.dot_value)
            flag_mismatch("dot_value", $signed(out_item_o.dot_value), $signed(want.dot_value));
          if (out_item_o.row_last !== want.row_last)
            flag_mismatch("row_last", out_item_o.row_last, want.row_last);
        end
      end
      pop <= !receiver_rests(idle_mode);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i or negedge rst_ni) begin : watchdog
    if (!rst_ni) begin
      stall_cnt <= 0;
    end else if ((push && !full) || (pop && !empty) || cfg_we_i) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

endmodule
